[rtl/segrt_pkg.sv]
`timescale 1ns / 1ps

package segrt_pkg;

    localparam int MAX_SEGS_DEF = 64;
    localparam int SEG_LEN_DEF  = 438;

    localparam int FIELD_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 15;
    localparam int IDX_MAX_W   = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    localparam logic [ADDR_W-1:0] BYTES_MAX = '1;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_NUMBER,
        ST_TOO_LONG,
        ST_SHORT
    } status_t;

    typedef struct packed {
        logic [FIELD_W-1:0]   block_type;
        logic [IDX_MAX_W-1:0] seg_idx;
        logic [IDX_MAX_W-1:0] seg_total;
        logic [FIELD_W-1:0]   seg_length;
        logic [ADDR_W-1:0]    base_addr;
        logic [BYTE_W-1:0]    payload_byte;
        logic                 byte_present;
        logic                 first;
        logic                 last;
        logic                 num_ok;
        status_t              status;
    } item_t;

endpackage

[rtl/segment_reassembly_tracker.sv]
`timescale 1ns / 1ps

// Rebuilds a memory block from numbered segments arriving one payload byte per transaction
// and gives exactly one result transaction for every input transaction, in order. The block
// sustains one transaction per clock cycle while neither side stalls: the whole per-byte
// update of the reassembly state (received map test, byte address add and counters) is done
// combinationally by the back unit. A result passes through the header check and address
// multiply stage, the two-entry queue and the output register, in that order. Either side
// may stall independently; a stall on the result side backs up through the queue to
// s_tready.
module segment_reassembly_tracker #(
    parameter int MAX_SEGS = segrt_pkg::MAX_SEGS_DEF,
    parameter int SEG_LEN  = segrt_pkg::SEG_LEN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // block_type, seg_number, seg_total, seg_length, payload_byte
    input  logic [segrt_pkg::S_TDATA_W-1:0] s_tdata,
    // byte_present, first_of_segment
    input  logic [segrt_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // write_address, write_data, status, was_duplicate, block_complete, block_bytes
    output logic [segrt_pkg::M_TDATA_W-1:0] m_tdata,
    // write_enable
    output logic [segrt_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                            m_tlast
);
    import segrt_pkg::*;

    logic  front_valid;
    logic  front_ready;
    item_t front_item;
    logic  queue_valid;
    logic  queue_ready;
    item_t queue_item;

    segrt_front #(
        .MAX_SEGS (MAX_SEGS),
        .SEG_LEN  (SEG_LEN)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    segrt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    segrt_back #(
        .MAX_SEGS (MAX_SEGS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .item       (queue_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

[rtl/segrt_front.sv]
`timescale 1ns / 1ps

module segrt_front #(
    parameter int MAX_SEGS = segrt_pkg::MAX_SEGS_DEF,
    parameter int SEG_LEN  = segrt_pkg::SEG_LEN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [segrt_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [segrt_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           s_tlast,
    output logic                           item_valid,
    input  logic                           item_ready,
    output segrt_pkg::item_t               item
);
    import segrt_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SEGS);
    localparam int LEN_W  = $clog2(SEG_LEN + 1);
    localparam int PROD_W = (IDX_W + LEN_W > ADDR_W) ? IDX_W + LEN_W : ADDR_W;

    logic [FIELD_W-1:0] in_type;
    logic [FIELD_W-1:0] in_num;
    logic [FIELD_W-1:0] in_total;
    logic [FIELD_W-1:0] in_len;
    logic               num_ok;
    logic               total_ok;
    status_t            status;
    logic [IDX_W-1:0]   idx;
    logic [PROD_W-1:0]  prod;
    item_t              cls;

    logic  stage_valid_reg;
    logic  stage_valid_next;
    item_t item_reg;

    assign in_type  = s_tdata[15:0];
    assign in_num   = s_tdata[31:16];
    assign in_total = s_tdata[47:32];
    assign in_len   = s_tdata[63:48];

    assign num_ok   = (in_num != '0) && (in_num < FIELD_W'(MAX_SEGS));
    assign total_ok = in_total < FIELD_W'(MAX_SEGS);

    always_comb begin
        if (!num_ok || !total_ok) begin
            status = ST_BAD_NUMBER;
        end else if (in_len > FIELD_W'(SEG_LEN)) begin
            status = ST_TOO_LONG;
        end else if ((in_num < in_total) && (in_len != FIELD_W'(SEG_LEN))) begin
            status = ST_SHORT;
        end else begin
            status = ST_OK;
        end
    end

    assign idx  = in_num[IDX_W-1:0] - IDX_W'(1);
    assign prod = PROD_W'(idx) * PROD_W'(SEG_LEN);

    always_comb begin
        cls.block_type   = in_type;
        cls.seg_idx      = IDX_MAX_W'(idx);
        cls.seg_total    = in_total[IDX_MAX_W-1:0];
        cls.seg_length   = in_len;
        cls.base_addr    = prod[ADDR_W-1:0];
        cls.payload_byte = s_tdata[71:64];
        cls.byte_present = s_tuser[0];
        cls.first        = s_tuser[1];
        cls.last         = s_tlast;
        cls.num_ok       = num_ok;
        cls.status       = status;
    end

    assign s_tready         = !stage_valid_reg || item_ready;
    assign stage_valid_next = (s_tvalid && s_tready) || (stage_valid_reg && !item_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= cls;
        end
    end

    assign item_valid = stage_valid_reg;
    assign item       = item_reg;

endmodule

[rtl/segrt_queue.sv]
`timescale 1ns / 1ps

module segrt_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  segrt_pkg::item_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output segrt_pkg::item_t out_item
);
    import segrt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign in_ready  = count_reg != CNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[rtl/segrt_back.sv]
`timescale 1ns / 1ps

module segrt_back #(
    parameter int MAX_SEGS = segrt_pkg::MAX_SEGS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  segrt_pkg::item_t                item,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [segrt_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [segrt_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                            m_tlast
);
    import segrt_pkg::*;

    localparam int IDX_W = $clog2(MAX_SEGS);
    localparam int PAD_W = M_TDATA_W - (2 * ADDR_W + BYTE_W + 4);

    logic [MAX_SEGS-1:0] map_reg;
    logic [MAX_SEGS-1:0] map_next;
    logic [IDX_W-1:0]    remaining_reg;
    logic [IDX_W-1:0]    remaining_next;
    logic [ADDR_W-1:0]   gathered_reg;
    logic [ADDR_W-1:0]   gathered_next;
    logic [FIELD_W-1:0]  type_reg;
    logic [FIELD_W-1:0]  type_next;
    logic                complete_reg;
    logic                complete_next;
    logic                accepting_reg;
    logic                accepting_next;
    logic [FIELD_W-1:0]  pos_reg;
    logic [FIELD_W-1:0]  pos_next;

    logic                    m_tvalid_reg;
    logic                    m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg;
    logic [M_TDATA_W-1:0]    m_tdata_next;
    logic [M_TUSER_W-1:0]    m_tuser_reg;
    logic [M_TUSER_W-1:0]    m_tuser_next;
    logic                    m_tlast_reg;
    logic                    m_tlast_next;

    logic                fire;
    logic                good;
    logic                restart_done;
    logic                restart_type;
    logic                restart;
    logic                fresh;
    logic [ADDR_W-1:0]   gath_a;
    logic [FIELD_W-1:0]  type_a;
    logic [ADDR_W-1:0]   gath_b;
    logic [MAX_SEGS-1:0] total_mask;
    logic [MAX_SEGS-1:0] map_c;
    logic [IDX_W-1:0]    idx;
    logic                acc_b;
    logic [FIELD_W-1:0]  pos_b;
    logic                wr;
    logic [ADDR_W-1:0]   waddr;
    logic [BYTE_W-1:0]   wdata;
    logic [IDX_W-1:0]    rem_b;
    logic                complete_b;
    logic                dup;
    logic [1:0]          status_out;
    logic [ADDR_W-1:0]   bytes_out;
    logic                complete_out;

    assign fire       = item_valid && (!m_tvalid_reg || m_tready);
    assign item_ready = !m_tvalid_reg || m_tready;
    assign good       = item.status == ST_OK;
    assign idx        = item.seg_idx[IDX_W-1:0];

    always_comb begin
        for (int i = 0; i < MAX_SEGS; i++) begin
            total_mask[i] = IDX_MAX_W'(i) < item.seg_total;
        end
    end

    always_comb begin
        restart_done = item.first && good && complete_reg;
        gath_a       = restart_done ? '0 : gathered_reg;
        type_a       = restart_done ? item.block_type : type_reg;
        restart_type = item.first && good && (gath_a != '0) && (type_a != item.block_type);
        restart      = restart_done || restart_type;
        gath_b       = restart ? '0 : gathered_reg;
        fresh        = item.first && good && (gath_b == '0);
        map_c        = (restart ? '0 : map_reg) | (fresh ? total_mask : '0);
        complete_b   = restart ? 1'b0 : complete_reg;
        rem_b        = fresh ? item.seg_total[IDX_W-1:0] : remaining_reg;
        acc_b        = item.first ? (good && map_c[idx]) : accepting_reg;
        pos_b        = item.first ? '0 : pos_reg;
        wr           = acc_b && item.byte_present && (pos_b < item.seg_length) && item.num_ok;
        waddr        = wr ? item.base_addr + pos_b[ADDR_W-1:0] : '0;
        wdata        = wr ? item.payload_byte : '0;

        type_next      = (restart || fresh) ? item.block_type : type_reg;
        gathered_next  = (wr && (gath_b != BYTES_MAX)) ? gath_b + ADDR_W'(1) : gath_b;
        pos_next       = wr ? pos_b + FIELD_W'(1) : pos_b;
        accepting_next = acc_b;
        map_next       = map_c;
        remaining_next = rem_b;
        complete_next  = complete_b;
        dup            = 1'b0;

        if (item.last) begin
            if (acc_b) begin
                if (item.num_ok) begin
                    map_next[idx] = 1'b0;
                end
                if (rem_b != '0) begin
                    remaining_next = rem_b - IDX_W'(1);
                    if (rem_b == IDX_W'(1)) begin
                        complete_next = 1'b1;
                    end
                end
            end else begin
                dup = good;
            end
            accepting_next = 1'b0;
            pos_next       = '0;
        end

        status_out   = item.last ? item.status : ST_OK;
        complete_out = item.last && complete_next;
        bytes_out    = item.last ? gathered_next : '0;
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{PAD_W{1'b0}}, bytes_out, complete_out, dup, status_out,
                             wdata, waddr};
            m_tuser_next  = M_TUSER_W'(wr);
            m_tlast_next  = item.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg       <= '0;
            remaining_reg <= '0;
            gathered_reg  <= '0;
            type_reg      <= '0;
            complete_reg  <= 1'b0;
            accepting_reg <= 1'b0;
            pos_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (fire) begin
                map_reg       <= map_next;
                remaining_reg <= remaining_next;
                gathered_reg  <= gathered_next;
                type_reg      <= type_next;
                complete_reg  <= complete_next;
                accepting_reg <= accepting_next;
                pos_reg       <= pos_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[rtl/segrt_checker.sv]
`timescale 1ns / 1ps

module segrt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [segrt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [segrt_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                            m_tlast
);
    import segrt_pkg::*;

    // A stalled result transaction must hold.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("result transaction changed while stalled");

    // Address and data are zero unless a byte is written.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[22:0] == '0)
    else $error("write fields set without a write");

    // Status fields are zero except at the end of a segment.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[41:23] == '0)
    else $error("status fields set before the end of a segment");

    // A duplicate only follows a good header and never writes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[25] |-> m_tdata[24:23] == ST_OK && !m_tuser[0])
    else $error("duplicate reported with bad status or a write");

endmodule

bind segment_reassembly_tracker segrt_checker u_segrt_checker (.*);

[tb/sv/segment_reassembly_tracker_tb.sv]
`timescale 1ns / 1ps

module segment_reassembly_tracker_tb;

    import segrt_pkg::*;

    localparam int MAX_SEGS   = MAX_SEGS_DEF;
    localparam int SEG_LEN    = SEG_LEN_DEF;
    localparam int N_RANDOM   = 900;
    localparam int IDLE_LIMIT = 5000;
    localparam int PRINT_MAX  = 40;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
        logic              done;
        status_t           st;
        logic              dup;
        logic              cmpl;
        logic [ADDR_W-1:0] bytes;
    } seg_result_t;

    typedef struct {
        bit [15:0]   btype;
        bit [15:0]   num;
        bit [15:0]   total;
        bit [15:0]   len;
        bit [7:0]    data;
        bit          present;
        bit          first;
        bit          last;
        bit          typed;
        seg_result_t want;
    } seg_item_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    seg_item_t   stim_q[$];
    seg_result_t write_q[$];
    int          n_sent     = 0;
    int          acc_idx    = 0;
    int          n_results  = 0;
    int          n_err      = 0;
    int          idle_count = 0;
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    bit [15:0]   stall_pat  = '1;
    int unsigned stall_age  = 0;

    // Reassembly state as the block should hold it.
    bit [MAX_SEGS-1:0] seg_map;
    int unsigned       segs_left;
    int unsigned       bytes_held;
    bit [15:0]         held_type;
    bit                blk_done;
    bit                seg_taking;
    int unsigned       seg_pos;

    bit [15:0] gen_type;
    bit [15:0] gen_total;

    segment_reassembly_tracker u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    task automatic add_row(input bit [15:0] btype, input bit [15:0] num,
                           input bit [15:0] total, input bit [15:0] len,
                           input bit [7:0] data, input bit present, input bit first,
                           input bit last, input bit typed, input seg_result_t want);
        seg_item_t it;
        it.btype   = btype;
        it.num     = num;
        it.total   = total;
        it.len     = len;
        it.data    = data;
        it.present = present;
        it.first   = first;
        it.last    = last;
        it.typed   = typed;
        it.want    = want;
        stim_q.push_back(it);
    endtask

    function automatic seg_result_t done_only(input status_t st, input bit dup);
        seg_result_t r;
        r      = '0;
        r.done = 1'b1;
        r.st   = st;
        r.dup  = dup;
        return r;
    endfunction

    function automatic void clear_block(input bit [15:0] btype);
        blk_done   = 1'b0;
        held_type  = btype;
        seg_map    = '0;
        bytes_held = 0;
    endfunction

    function automatic seg_result_t step_reassembly(input seg_item_t it);
        seg_result_t r;
        status_t     st;
        int unsigned addr;
        r = '0;
        if (it.num == 0 || it.num >= MAX_SEGS || it.total >= MAX_SEGS) begin
            st = ST_BAD_NUMBER;
        end else if (it.len > SEG_LEN) begin
            st = ST_TOO_LONG;
        end else if (it.num < it.total && it.len != SEG_LEN) begin
            st = ST_SHORT;
        end else begin
            st = ST_OK;
        end
        if (it.first) begin
            seg_taking = 1'b0;
            seg_pos    = 0;
            if (st == ST_OK) begin
                if (blk_done)
                    clear_block(it.btype);
                if (bytes_held != 0 && held_type != it.btype)
                    clear_block(it.btype);
                if (bytes_held == 0) begin
                    held_type = it.btype;
                    segs_left = it.total;
                    for (int i = 0; i < it.total; i++)
                        seg_map[i] = 1'b1;
                end
                if (seg_map[it.num - 1])
                    seg_taking = 1'b1;
            end
        end
        if (seg_taking && it.present && seg_pos < it.len && it.num >= 1
            && it.num < MAX_SEGS) begin
            addr    = (it.num - 1) * SEG_LEN + seg_pos;
            r.we    = 1'b1;
            r.addr  = addr[ADDR_W-1:0];
            r.wdata = it.data;
            seg_pos++;
            if (bytes_held < BYTES_MAX)
                bytes_held++;
        end
        if (it.last) begin
            if (seg_taking) begin
                if (it.num >= 1 && it.num < MAX_SEGS)
                    seg_map[it.num - 1] = 1'b0;
                if (segs_left != 0) begin
                    segs_left--;
                    if (segs_left == 0)
                        blk_done = 1'b1;
                end
            end else if (st == ST_OK) begin
                r.dup = 1'b1;
            end
            seg_taking = 1'b0;
            seg_pos    = 0;
            r.done     = 1'b1;
            r.st       = st;
            r.cmpl     = blk_done;
            r.bytes    = bytes_held[ADDR_W-1:0];
        end
        return r;
    endfunction

    task automatic build_random(input int unsigned n_items);
        int unsigned made;
        int unsigned n;
        int unsigned r;
        int unsigned extra;
        bit [15:0]   num;
        bit [15:0]   total;
        bit [15:0]   len;
        bit          present;
        bit          drop_first;
        bit          drop_last;
        made      = 0;
        gen_type  = 16'h1234;
        gen_total = 16'd2;
        while (made < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                    add_row(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                            1'b0, '0);
            end else begin
                if ($urandom_range(0, 4) == 0)
                    gen_type = 16'($urandom);
                if ($urandom_range(0, 4) == 0)
                    gen_total = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 3))
                                                           : 16'($urandom_range(0, 63));
                total = gen_total;
                if ($urandom_range(0, 19) == 0)
                    total = 16'($urandom_range(64, 65535));
                r = $urandom_range(0, 99);
                if (r < 3)
                    num = 16'd0;
                else if (r < 60)
                    num = (total == 0 || total >= MAX_SEGS) ? 16'd1 : total;
                else if (r < 90)
                    num = 16'($urandom_range(1, (total >= 1 && total < MAX_SEGS) ? total : 1));
                else
                    num = 16'($urandom_range(1, MAX_SEGS - 1));
                r = $urandom_range(0, 99);
                if (num < total)
                    len = (r < 10) ? 16'(SEG_LEN) : 16'($urandom_range(0, 6));
                else if (r < 2)
                    len = 16'(SEG_LEN);
                else if (r < 7)
                    len = 16'($urandom_range(SEG_LEN + 1, 65535));
                else
                    len = 16'($urandom_range(0, 6));
                extra      = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
                n          = ((len > SEG_LEN) ? 2 : len) + extra;
                n          = (n == 0) ? 1 : n;
                drop_first = ($urandom_range(0, 19) == 0);
                drop_last  = ($urandom_range(0, 19) == 0);
                for (int k = 0; k < n; k++) begin
                    present = (len == 0) ? 1'($urandom) : ($urandom_range(0, 11) != 0);
                    add_row(gen_type, num, total, len, 8'($urandom), present,
                            k == 0 && !drop_first, k == n - 1 && !drop_last, 1'b0, '0);
                end
            end
            made += n;
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (n_err < PRINT_MAX)
            $display("MISMATCH result %0d %s: got %0d expected %0d",
                     n_results, what, got, want);
        n_err++;
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        int nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            nxt = n_sent + ((s_tvalid && s_tready) ? 1 : 0);
            n_sent <= nxt;
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (nxt < stim_q.size()) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {stim_q[nxt].data, stim_q[nxt].len, stim_q[nxt].total,
                                 stim_q[nxt].num, stim_q[nxt].btype};
                    s_tuser  <= {stim_q[nxt].first, stim_q[nxt].present};
                    s_tlast  <= stim_q[nxt].last;
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 30);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: a rotating stall pattern, replaced by a new random one whenever its age counter wraps.
    always @(posedge aclk) begin
        if (stall_age == 63) begin
            case ($urandom_range(0, 3))
                0: begin
                    stall_pat <= '1;
                end
                1: begin
                    stall_pat <= 16'($urandom) & 16'($urandom);
                end
                default: begin
                    stall_pat <= 16'($urandom);
                end
            endcase
            stall_age <= 0;
        end else begin
            stall_pat <= {stall_pat[0], stall_pat[15:1]};
            stall_age <= stall_age + 1;
        end
        m_tready <= stall_pat[0];
    end

    always @(posedge aclk) begin
        seg_result_t got;
        seg_result_t want;
        seg_result_t r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.we    = m_tuser[0];
                got.addr  = m_tdata[14:0];
                got.wdata = m_tdata[22:15];
                got.done  = m_tlast;
                got.st    = status_t'(m_tdata[24:23]);
                got.dup   = m_tdata[25];
                got.cmpl  = m_tdata[26];
                got.bytes = m_tdata[41:27];
                if (write_q.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, 0);
                end else begin
                    want = write_q.pop_front();
                    if (got.we !== want.we)
                        report_mismatch("write_enable", got.we, want.we);
                    if (got.addr !== want.addr)
                        report_mismatch("write_address", got.addr, want.addr);
                    if (got.wdata !== want.wdata)
                        report_mismatch("write_data", got.wdata, want.wdata);
                    if (got.done !== want.done)
                        report_mismatch("segment_done", got.done, want.done);
                    if (got.st !== want.st)
                        report_mismatch("status", got.st, want.st);
                    if (got.dup !== want.dup)
                        report_mismatch("was_duplicate", got.dup, want.dup);
                    if (got.cmpl !== want.cmpl)
                        report_mismatch("block_complete", got.cmpl, want.cmpl);
                    if (got.bytes !== want.bytes)
                        report_mismatch("block_bytes", got.bytes, want.bytes);
                end
                n_results++;
            end
            if (s_tvalid && s_tready) begin
                r = step_reassembly(stim_q[acc_idx]);
                write_q.push_back(stim_q[acc_idx].typed ? stim_q[acc_idx].want : r);
                acc_idx++;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        seg_map    = '0;
        segs_left  = 0;
        bytes_held = 0;
        held_type  = '0;
        blk_done   = 1'b0;
        seg_taking = 1'b0;
        seg_pos    = 0;

        // Header errors straight after reset, then items outside a segment.
        add_row(16'h0000, 16'd0, 16'd1, 16'd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1,
                done_only(ST_BAD_NUMBER, 1'b0));
        add_row(16'h0000, 16'd64, 16'd1, 16'd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1,
                done_only(ST_BAD_NUMBER, 1'b0));
        add_row(16'h0000, 16'd1, 16'd64, 16'd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1,
                done_only(ST_BAD_NUMBER, 1'b0));
        add_row(16'h0000, 16'd1, 16'd1, 16'd439, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1,
                done_only(ST_TOO_LONG, 1'b0));
        add_row(16'h0000, 16'd1, 16'd2, 16'd5, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1,
                done_only(ST_SHORT, 1'b0));
        add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1,
                done_only(ST_BAD_NUMBER, 1'b0));
        add_row(16'h0000, 16'd1, 16'd1, 16'd1, 8'h77, 1'b1, 1'b0, 1'b1, 1'b1,
                done_only(ST_OK, 1'b1));
        add_row(16'h0000, 16'd1, 16'd1, 16'd1, 8'h77, 1'b1, 1'b0, 1'b0, 1'b1, '0);

        // One-segment block with a gap byte and a byte past the length.
        add_row(16'hA5A5, 16'd1, 16'd1, 16'd2, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, '0);
        add_row(16'hA5A5, 16'd1, 16'd1, 16'd2, 8'h11, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(16'hA5A5, 16'd1, 16'd1, 16'd2, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(16'hA5A5, 16'd1, 16'd1, 16'd2, 8'h5A, 1'b1, 1'b0, 1'b1, 1'b0, '0);
        // Empty segment after a completed block, then the highest segment number.
        add_row(16'hA5A5, 16'd1, 16'd1, 16'd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, '0);
        add_row(16'h0001, 16'd63, 16'd63, 16'd1, 8'h3C, 1'b1, 1'b1, 1'b1, 1'b0, '0);
        add_row(16'h0001, 16'd63, 16'd63, 16'd1, 8'hC3, 1'b1, 1'b1, 1'b1, 1'b0, '0);
        add_row(16'hFFFF, 16'd63, 16'd63, 16'd1, 8'h96, 1'b1, 1'b1, 1'b1, 1'b0, '0);
        // A partial block, then a type change, a short non-final segment and zero count.
        add_row(16'h0002, 16'd5, 16'd5, 16'd438, 8'h81, 1'b1, 1'b1, 1'b0, 1'b0, '0);
        add_row(16'h0002, 16'd5, 16'd5, 16'd438, 8'h7E, 1'b1, 1'b0, 1'b1, 1'b0, '0);
        add_row(16'h0002, 16'd1, 16'd63, 16'd1, 8'h42, 1'b1, 1'b1, 1'b1, 1'b0, '0);
        add_row(16'h0003, 16'd2, 16'd0, 16'd1, 8'h24, 1'b1, 1'b1, 1'b1, 1'b0, '0);
        add_row(16'h0003, 16'd2, 16'd0, 16'd1, 8'h24, 1'b1, 1'b1, 1'b1, 1'b0, '0);
        add_row(16'h0003, 16'd3, 16'd0, 16'd1, 8'h99, 1'b1, 1'b0, 1'b1, 1'b0, '0);

        build_random(N_RANDOM);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (acc_idx < stim_q.size() || write_q.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);

        if (n_err == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
